// ===== design/nlz_pkg.sv =====
// ----------------------------------------------------------------------------
// nlz_pkg: shared constants and types of the zero-crossing edge core
// Holds the config indexes, the dimension limits and the result type that
// the front and back parts pass through the queue.
// ----------------------------------------------------------------------------
package nlz_pkg;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_RADIUS = 2;
  localparam int HEIGHT_LIMIT = 1024;
  localparam logic [7:0] EDGE_MARK = 8'd0;
  localparam logic [7:0] PLAIN_MARK = 8'd255;
  localparam logic [10:0] RESET_DIM = 11'd512;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] value;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
    logic       done;
  } result_t;

  function automatic logic [7:0] judge(input logic signed [9:0] here,
                                       input logic signed [9:0] right,
                                       input logic signed [9:0] below);
    judge = (here < 0 && (right > 0 || below > 0)) ? EDGE_MARK : PLAIN_MARK;
  endfunction
endpackage

// ===== design/nlz_front.sv =====
// ----------------------------------------------------------------------------
// nlz_front: window, Laplacian and classification
// Holds the pixel line store and the window, forms the Laplacian of each
// interior pixel and judges it against the stored line, producing up to
// three results per pixel. Two stages: window update, then judgement.
// ----------------------------------------------------------------------------
module nlz_front #(
  parameter int MAX_WIDTH = nlz_pkg::DEF_MAX_WIDTH,
  parameter int RADIUS = nlz_pkg::DEF_RADIUS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [10:0]         width,
  input  logic [10:0]         height,
  input  logic                in_fire,
  input  logic [7:0]          pixel,
  output logic                res_valid,
  output logic [1:0]          res_count,
  output nlz_pkg::result_t    res0,
  output nlz_pkg::result_t    res1,
  output nlz_pkg::result_t    res2
);
  import nlz_pkg::*;

  localparam int SIDE = 2 * RADIUS + 1;
  localparam int LINES = 2 * RADIUS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [10:0] W_LIMIT = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);

  // pixel line store: a single memory, each word packed as a column of LINES pixels
  logic [LINES*8-1:0] pline [MAX_WIDTH];
  logic [LINES*8-1:0] pline_rd;
  logic signed [9:0]  lline [MAX_WIDTH];
  logic [7:0] win [SIDE][SIDE];
  // max and min of the window columns that survive the next shift
  logic [7:0] cmax [SIDE-1];
  logic [7:0] cmin [SIDE-1];

  logic [10:0] row_counter, col_counter;
  logic [10:0] w, h;
  logic [10:0] r, c;

  // stage 1 registers
  logic        s1_valid;
  logic [10:0] s1_r, s1_c;
  logic [7:0]  s1_pixel;
  logic [10:0] s1_lc;

  // stage 2 registers
  logic        s2_valid;
  logic [10:0] s2_r, s2_c;
  logic        s2_interior;
  logic [7:0]  s2_max, s2_min, s2_ctr;
  logic signed [9:0] s2_up, s2_up_right, prev_lap;

  always_comb begin
    w = (width < 11'(SIDE)) ? 11'(SIDE) : (width > W_LIMIT) ? W_LIMIT : width;
    h = (height < 11'(SIDE)) ? 11'(SIDE) :
        (height > 11'(HEIGHT_LIMIT)) ? 11'(HEIGHT_LIMIT) : height;
    if (row_counter >= h || col_counter >= w) begin
      r = '0;
      c = '0;
    end else begin
      r = row_counter;
      c = col_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (in_fire) begin
      if (c + 11'd1 >= w) begin
        col_counter <= '0;
        row_counter <= (r + 11'd1 >= h) ? '0 : r + 11'd1;
      end else begin
        col_counter <= c + 11'd1;
      end
    end
  end

  // stage 0 -> 1: read line column, shift store column
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pline_rd <= pline[c[CW-1:0]];
    end
    if (s1_valid) begin
      pline[s1_c[CW-1:0]] <= {s1_pixel, pline_rd[LINES*8-1:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
    s1_r <= r;
    s1_c <= c;
    s1_pixel <= pixel;
  end

  // window shift and max/min over the new window
  logic [7:0] col_in [SIDE];
  logic [7:0] nwin [SIDE][SIDE];
  logic [7:0] cmax_in, cmin_in;
  logic [7:0] mx, mn;
  always_comb begin
    for (int y = 0; y < SIDE; y++) begin
      col_in[y] = (y < LINES) ? pline_rd[y*8 +: 8] : s1_pixel;
      for (int x = 0; x < SIDE - 1; x++) nwin[y][x] = win[y][x+1];
      nwin[y][SIDE-1] = col_in[y];
    end
    cmax_in = col_in[0];
    cmin_in = col_in[0];
    for (int y = 1; y < SIDE; y++) begin
      if (col_in[y] > cmax_in) cmax_in = col_in[y];
      if (col_in[y] < cmin_in) cmin_in = col_in[y];
    end
    mx = cmax_in;
    mn = cmin_in;
    for (int x = 0; x < SIDE - 1; x++) begin
      if (cmax[x] > mx) mx = cmax[x];
      if (cmin[x] < mn) mn = cmin[x];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < SIDE; y++)
        for (int x = 0; x < SIDE; x++) win[y][x] <= 8'd0;
      for (int x = 0; x < SIDE - 1; x++) begin
        cmax[x] <= 8'd0;
        cmin[x] <= 8'd0;
      end
    end else if (s1_valid) begin
      win <= nwin;
      for (int x = 0; x < SIDE - 2; x++) begin
        cmax[x] <= cmax[x+1];
        cmin[x] <= cmin[x+1];
      end
      cmax[SIDE-2] <= cmax_in;
      cmin[SIDE-2] <= cmin_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_r <= s1_r;
    s2_c <= s1_c;
    s2_interior <= s1_r >= 11'(LINES) && s1_c >= 11'(LINES);
    s2_max <= mx;
    s2_min <= mn;
    s2_ctr <= nwin[RADIUS][RADIUS];
  end

  // stage 1 -> 2: fetch the stored Laplacian above and above-right
  assign s1_lc = s1_c - 11'(RADIUS);
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_up <= lline[s1_lc[CW-1:0]];
      s2_up_right <= lline[CW'(s1_lc + 11'd1)];
    end
  end

  // stage 2: Laplacian and judgement against the stored line
  logic signed [9:0] lap, l_up, l_right, l_left;
  logic [10:0] lr, lc;
  logic        e0, e1, e2;
  always_comb begin
    lap = 10'(signed'({2'b00, s2_max}) + signed'({2'b00, s2_min})
          - signed'({1'b0, s2_ctr, 1'b0}));
    lr = s2_r - 11'(RADIUS);
    lc = s2_c - 11'(RADIUS);
    l_up = s2_up;
    l_right = (lc + 11'd1 <= w - 11'd1 - 11'(RADIUS)) ? s2_up_right : 10'sd0;
    // the left neighbour on this row is the previous interior pixel
    l_left = prev_lap;
    e0 = s2_valid && s2_interior && lr >= 11'(RADIUS + 1);
    e1 = s2_valid && s2_interior && s2_r == h - 11'd1 && lc >= 11'(RADIUS + 1);
    e2 = s2_valid && s2_interior && s2_r == h - 11'd1 && s2_c == w - 11'd1;
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_interior) begin
      lline[lc[CW-1:0]] <= lap;
      prev_lap <= lap;
    end
  end

  result_t q0, q1, q2;
  always_comb begin
    q0 = '{value: judge(l_up, l_right, lap), row: 10'(lr - 11'd1), col: lc[9:0],
           last: 1'b0, done: 1'b0};
    q1 = '{value: judge(l_left, lap, 10'sd0), row: lr[9:0], col: 10'(lc - 11'd1),
           last: 1'b0, done: 1'b0};
    q2 = '{value: judge(lap, 10'sd0, 10'sd0), row: lr[9:0], col: lc[9:0],
           last: 1'b0, done: 1'b1};
    res_valid = s2_valid;
    res_count = 2'(e0) + 2'(e1) + 2'(e2);
    res0 = e0 ? q0 : (e1 ? q1 : q2);
    res1 = (e0 && e1) ? q1 : q2;
    res2 = q2;
  end
endmodule

// ===== design/nlz_back.sv =====
// ----------------------------------------------------------------------------
// nlz_back: result queue and output packer
// Takes the per-pixel result groups, keeps the model's grouping (at most two
// per pixel, overflow carried ahead of the next group) and delivers one
// result per transfer through a small FIFO.
// ----------------------------------------------------------------------------
module nlz_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             grp_valid,
  input  logic [1:0]       grp_count,
  input  nlz_pkg::result_t g0,
  input  nlz_pkg::result_t g1,
  input  nlz_pkg::result_t g2,
  output logic             out_valid,
  input  logic             out_stall,
  output nlz_pkg::result_t out_res
);
  import nlz_pkg::*;

  localparam int DEPTH = 16;
  localparam int AW = $clog2(DEPTH);

  result_t fifo [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;
  logic          carry_valid;
  result_t       carry;

  result_t list [3];
  logic [2:0] n;
  logic [1:0] emit;
  result_t e0, e1;
  logic pop;

  always_comb begin
    list[0] = carry_valid ? carry : g0;
    list[1] = carry_valid ? g0 : g1;
    list[2] = carry_valid ? g1 : g2;
    n = 3'(grp_count) + 3'(carry_valid);
    emit = (n > 3'd2) ? 2'd2 : n[1:0];
    e0 = list[0];
    e1 = list[1];
    e0.last = (emit == 2'd1);
    e1.last = 1'b1;
    pop = out_valid && !out_stall;
  end

  assign out_valid = fill != '0;
  assign out_res = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (grp_valid && emit != 2'd0) fifo[wr_ptr] <= e0;
    if (grp_valid && emit == 2'd2) fifo[AW'(wr_ptr + 1'b1)] <= e1;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
      carry_valid <= 1'b0;
    end else begin
      if (grp_valid) begin
        wr_ptr <= wr_ptr + AW'(emit);
        carry_valid <= n == 3'd3;
        carry <= list[2];
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (grp_valid ? (AW+1)'(emit) : '0) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= (AW+1)'(DEPTH))
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (rst || restart)
    grp_valid && n == 3'd3 |=> carry_valid)
    else $error("overflow result lost");
endmodule

// ===== design/nonlinear_laplacian_zero_cross_edge_core.sv =====
// ----------------------------------------------------------------------------
// nonlinear_laplacian_zero_cross_edge_core: 5x5 morphological Laplacian edges
// Top level: config registers, front classifier and back result queue.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and emits the edge mark of each
// interior pixel, tagged with its row and column, one result per transfer
// through a 16-entry queue. A result passes the front stage registers and
// the queue before it is offered. The last pixel of a frame completes up to
// three results; if three, the frame_done one goes out with the next pixel.
// The input stalls while more than eight results are held, which leaves room
// for the results of the pixels still in the front pipeline. Writing a
// register restarts the frame and drops a held result; write only while
// idle. Line stores need no clearing pass.
module nonlinear_laplacian_zero_cross_edge_core #(
  parameter int MAX_WIDTH = nlz_pkg::DEF_MAX_WIDTH,
  parameter int RADIUS = nlz_pkg::DEF_RADIUS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  edge_value,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        last_of_run,
  output logic        frame_done
);
  import nlz_pkg::*;

  logic [10:0] image_width, image_height;
  logic restart, in_fire, grp_valid;
  logic [1:0] grp_count;
  result_t g0, g1, g2, res;
  logic [4:0] fill_est;

  assign restart = cfg_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= RESET_DIM;
      image_height <= RESET_DIM;
    end else if (cfg_write) begin
      if (cfg_index == REG_WIDTH) image_width <= cfg_data;
      else image_height <= cfg_data;
    end
  end

  // credit: count of results the front has produced and the queue has not popped
  logic [4:0] used;
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      used <= '0;
    end else begin
      used <= used + (grp_valid ? 5'(grp_count) : 5'd0)
              - 5'(out_valid && !out_stall);
    end
  end
  assign fill_est = used;
  assign in_stall = fill_est > 5'd8;
  assign in_fire = in_valid && !in_stall;

  nlz_front #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_front (
    .clk(clk), .rst(rst), .restart(restart), .width(image_width),
    .height(image_height), .in_fire(in_fire), .pixel(pixel),
    .res_valid(grp_valid), .res_count(grp_count), .res0(g0), .res1(g1), .res2(g2)
  );

  nlz_back u_back (
    .clk(clk), .rst(rst), .restart(restart), .grp_valid(grp_valid),
    .grp_count(grp_count), .g0(g0), .g1(g1), .g2(g2),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign edge_value = res.value;
  assign out_row = res.row;
  assign out_col = res.col;
  assign last_of_run = res.last;
  assign frame_done = res.done;
endmodule

// ===== sim/nlz_edge_checker.sv =====
// ----------------------------------------------------------------------------
// nlz_edge_checker: result predictor and scoreboard for the edge core
// Watches the config port and both channels, predicts the edge marks of
// every accepted pixel and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module nlz_edge_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  pixel,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  edge_value,
  input  logic [9:0]  out_row,
  input  logic [9:0]  out_col,
  input  logic        last_of_run,
  input  logic        frame_done,
  output int          errors,
  output int          pending
);
  import nlz_pkg::*;

  logic [7:0]        pix_lines [4][1024];
  logic signed [9:0] lap_line [1024];
  logic [7:0]        win [5][5];
  int unsigned       row_pos, col_pos;
  logic [10:0]       width_reg, height_reg;
  result_t           edge_expect_q[$];
  result_t           carry_over[$];

  assign pending = edge_expect_q.size();

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned lim);
    if (v < 5) return 5;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic logic [7:0] mark_of(input int here, input int right, input int below);
    return (here < 0 && (right > 0 || below > 0)) ? EDGE_MARK : PLAIN_MARK;
  endfunction

  function automatic result_t make_res(input logic [7:0] v, input int unsigned r,
                                       input int unsigned c, input logic d);
    result_t t;
    t.value = v;
    t.row   = r[9:0];
    t.col   = c[9:0];
    t.last  = 1'b0;
    t.done  = d;
    return t;
  endfunction

  task automatic predict_pixel(input logic [7:0] p);
    int unsigned w, h, r, c, lr, lc;
    int mx, mn, lap, up, right, emit;
    result_t batch[$];
    result_t t;
    w = clamp_dim(width_reg, 1024);
    h = clamp_dim(height_reg, HEIGHT_LIMIT);
    if (row_pos >= h || col_pos >= w) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    batch = carry_over;
    carry_over.delete();
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
      win[y][4] = (y < 4) ? pix_lines[y][c] : p;
    end
    for (int y = 0; y < 3; y++) pix_lines[y][c] = pix_lines[y+1][c];
    pix_lines[3][c] = p;
    if (r >= 4 && c >= 4) begin
      mx = 0;
      mn = 255;
      for (int y = 0; y < 5; y++)
        for (int x = 0; x < 5; x++) begin
          if (int'(win[y][x]) > mx) mx = int'(win[y][x]);
          if (int'(win[y][x]) < mn) mn = int'(win[y][x]);
        end
      lap = mx + mn - 2 * int'(win[2][2]);
      lr = r - 2;
      lc = c - 2;
      if (lr >= 3) begin
        up = int'(lap_line[lc]);
        right = (lc + 1 <= w - 3) ? int'(lap_line[lc+1]) : 0;
        batch.push_back(make_res(mark_of(up, right, lap), lr - 1, lc, 1'b0));
      end
      if (r == h - 1) begin
        if (lc >= 3)
          batch.push_back(make_res(mark_of(int'(lap_line[lc-1]), lap, 0),
                                   lr, lc - 1, 1'b0));
        if (c == w - 1)
          batch.push_back(make_res(mark_of(lap, 0, 0), lr, lc, 1'b1));
      end
      lap_line[lc] = lap[9:0];
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    emit = (batch.size() > 2) ? 2 : batch.size();
    for (int k = 0; k < batch.size(); k++) begin
      t = batch[k];
      if (k < emit) begin
        t.last = (k == emit - 1);
        edge_expect_q.push_back(t);
      end else if (carry_over.size() < 2) begin
        carry_over.push_back(t);
      end
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      errors = 0;
      for (int y = 0; y < 4; y++)
        for (int x = 0; x < 1024; x++) pix_lines[y][x] = '0;
      for (int x = 0; x < 1024; x++) lap_line[x] = '0;
      for (int y = 0; y < 5; y++)
        for (int x = 0; x < 5; x++) win[y][x] = '0;
      row_pos = 0;
      col_pos = 0;
      width_reg = RESET_DIM;
      height_reg = RESET_DIM;
      carry_over.delete();
      edge_expect_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (edge_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result row %0d col %0d value %0d",
                   $time, out_row, out_col, edge_value);
        end else begin
          e = edge_expect_q.pop_front();
          if (e.value !== edge_value || e.row !== out_row || e.col !== out_col ||
              e.last !== last_of_run || e.done !== frame_done) begin
            errors++;
            $display("%0t: mismatch exp value %0d row %0d col %0d last %0b done %0b",
                     $time, e.value, e.row, e.col, e.last, e.done);
            $display("%0t:          act value %0d row %0d col %0d last %0b done %0b",
                     $time, edge_value, out_row, out_col, last_of_run, frame_done);
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        row_pos = 0;
        col_pos = 0;
        carry_over.delete();
      end
      if (in_valid && !in_stall) predict_pixel(pixel);
    end
  end
endmodule

// ===== sim/nonlinear_laplacian_zero_cross_edge_core_tb.sv =====
// ----------------------------------------------------------------------------
// nonlinear_laplacian_zero_cross_edge_core_tb: stimulus and verdict
// Runs directed and random frames of many sizes through the edge core under
// varying sender gaps and receiver stalls; the checker does the comparing.
// ----------------------------------------------------------------------------
module nonlinear_laplacian_zero_cross_edge_core_tb;
  import nlz_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = REG_WIDTH;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  edge_value;
  logic [9:0]  out_row, out_col;
  logic        last_of_run, frame_done;
  int          errors, pending;

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int random_sent = 0;

  always #5 clk = ~clk;

  nonlinear_laplacian_zero_cross_edge_core uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall, .pixel,
    .out_valid, .out_stall, .edge_value, .out_row, .out_col, .last_of_run, .frame_done
  );

  nlz_edge_checker chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall, .pixel,
    .out_valid, .out_stall, .edge_value, .out_row, .out_col, .last_of_run, .frame_done,
    .errors, .pending
  );

  // receiver: random stalls, plus a long hold when requested
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [10:0] v);
    if (v < 5) return 5;
    if (v > 1024) return 1024;
    return 32'(v);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(2))
      0: return 8'($urandom);
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'(8'd120 + $urandom_range(16));
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_pixel(input logic [7:0] p);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    pixel = p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [10:0] v);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 48; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 48; end
      default: begin gap_pct = 37; stall_pct = 37; end
    endcase
  endtask

  initial begin
    int unsigned w, h, n;
    logic [10:0] wv, hv;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // reset dimensions, a few pixels only
    for (int i = 0; i < 6; i++) send_pixel(i[0] ? 8'hFF : 8'h00);
    wait_idle();

    // smallest frame, checkerboard of the extremes
    write_reg(REG_WIDTH, 11'd5);
    write_reg(REG_HEIGHT, 11'd5);
    for (int i = 0; i < 25; i++) send_pixel(((i / 5 + i % 5) % 2) ? 8'hFF : 8'h00);
    // run into the next frame with three more pixels
    for (int i = 0; i < 3; i++) send_pixel(8'd128);
    wait_idle();

    // dimensions below the minimum clamp up
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd3);
    for (int i = 0; i < 27; i++) send_pixel(rand_pixel());
    wait_idle();

    for (int ph = 0; random_sent < 700; ph++) begin
      set_mode(ph);
      wv = ($urandom_range(7) == 0) ? 11'($urandom_range(4)) : 11'($urandom_range(5, 12));
      hv = ($urandom_range(7) == 0) ? 11'($urandom_range(4)) : 11'($urandom_range(5, 10));
      if ($urandom_range(1)) begin
        write_reg(REG_HEIGHT, hv);
        write_reg(REG_WIDTH, wv);
      end else begin
        write_reg(REG_WIDTH, wv);
        write_reg(REG_HEIGHT, hv);
      end
      w = clamp_dim(wv);
      h = clamp_dim(hv);
      n = w * h * $urandom_range(1, 2) + $urandom_range(w);
      // an occasional cut-short frame
      if ($urandom_range(5) == 0) n = $urandom_range(1, w * h);
      for (int unsigned i = 0; i < n; i++) send_pixel(rand_pixel());
      random_sent += n;
      wait_idle();
    end

    // hold the receiver off so the core fills and stalls
    set_mode(0);
    write_reg(REG_WIDTH, 11'd10);
    write_reg(REG_HEIGHT, 11'd8);
    hold_requests++;
    for (int i = 0; i < 10 * 8 + 2; i++) send_pixel(rand_pixel());
    wait_idle();

    // oversize values clamp to the limits
    set_mode(3);
    write_reg(REG_WIDTH, 11'd2047);
    write_reg(REG_HEIGHT, 11'd5);
    for (int i = 0; i < 30; i++) send_pixel(rand_pixel());
    wait_idle();
    set_mode(2);
    write_reg(REG_WIDTH, 11'd5);
    write_reg(REG_HEIGHT, 11'd2047);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
    wait_idle();

    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/nlz_pkg.sv
design/nlz_front.sv
design/nlz_back.sv
design/nonlinear_laplacian_zero_cross_edge_core.sv
sim/nlz_edge_checker.sv
sim/nonlinear_laplacian_zero_cross_edge_core_tb.sv
